// ----- hdl/ssq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the squarefree/square split block.
// No dependencies; used by every module of the block.
package ssq_pkg;

  localparam int VALUE_BITS = 31;
  localparam int D_BITS     = (VALUE_BITS + 2) / 2;
  localparam int DSQ_BITS   = 2 * D_BITS;
  localparam int CMP_BITS   = (DSQ_BITS > VALUE_BITS) ? DSQ_BITS : VALUE_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

  localparam int IN_W       = 32;
  localparam int SQF_W      = 31;
  localparam int ROOT_W     = 16;
  localparam int STATUS_W   = 1;
  localparam int OUT_W      = 48;

  localparam logic [63:0] VALUE_LIMIT = (64'd1 << VALUE_BITS) - 64'd1;

  localparam logic [STATUS_W-1:0] STATUS_OK  = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_ERR = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [D_BITS-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [D_BITS-1:0]     remainder;
  } div_res_t;

endpackage

// ----- hdl/ssq_div.sv -----
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ssq_pkg for widths and the request/result structs.
module ssq_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssq_pkg::div_req_t req_i,
  output ssq_pkg::div_res_t res_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [ssq_pkg::CNT_BITS-1:0]    cnt_q;
  logic [ssq_pkg::VALUE_BITS-1:0]  quo_q, quo_d;
  logic [ssq_pkg::D_BITS-1:0]      rem_q, rem_d;
  logic [ssq_pkg::D_BITS-1:0]      divisor_q;
  logic [ssq_pkg::D_BITS:0]        trial;
  logic [ssq_pkg::D_BITS:0]        diff;
  logic                            fits;

  always_comb begin
    trial = {rem_q, quo_q[ssq_pkg::VALUE_BITS-1]};
    diff  = trial - {1'b0, divisor_q};
    fits  = ~diff[ssq_pkg::D_BITS];
    rem_d = fits ? diff[ssq_pkg::D_BITS-1:0] : trial[ssq_pkg::D_BITS-1:0];
    quo_d = {quo_q[ssq_pkg::VALUE_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ssq_pkg::CNT_BITS'(ssq_pkg::VALUE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ssq_pkg::CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

// ----- hdl/squarefree_square_split_top.sv -----
`timescale 1ns / 1ps
// Top level: sequencer, shared multiplier and output register of the split block.
// Depends on ssq_pkg and ssq_div.
//
// Splits a positive 32-bit input n into a * b * b with a squarefree, by trial
// division with divisors 2, 3, 4, ... while the divisor squared stays within the
// remainder. Each trial division runs on one shared iterative divider that
// produces one quotient bit per cycle; each new trial divisor adds a compare
// step in ST_CHECK. Inputs of zero, negative inputs and inputs above
// 2^VALUE_BITS - 1 give status 1 with zero parts. s_axis_tready is high only
// while no item is in work; a finished result waits in the output register
// while the next item is taken.
module squarefree_square_split_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ssq_pkg::IN_W-1:0]   s_axis_tdata,   // [31:0] n_value
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ssq_pkg::OUT_W-1:0]  m_axis_tdata    // [30:0] squarefree_part,
                                                     // [46:31] square_root_part,
                                                     // [47] status
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_START = 7'b0000100,
    ST_WAIT  = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  localparam int VB = ssq_pkg::VALUE_BITS;

  state_e                          state_q, state_d;
  logic [VB-1:0]                   m_q, m_d;
  logic [ssq_pkg::D_BITS-1:0]      d_q, d_d;
  logic [ssq_pkg::DSQ_BITS-1:0]    dsq_q, dsq_d;
  logic [VB-1:0]                   a_q, a_d;
  logic [ssq_pkg::D_BITS-1:0]      b_q, b_d;
  logic                            par_q, par_d;
  logic [ssq_pkg::STATUS_W-1:0]    err_q, err_d;

  logic                            out_valid_q, out_valid_d;
  logic [ssq_pkg::SQF_W-1:0]       out_sqf_q;
  logic [ssq_pkg::ROOT_W-1:0]      out_root_q;
  logic [ssq_pkg::STATUS_W-1:0]    out_status_q;
  logic                            out_load;

  ssq_pkg::div_req_t               div_req;
  ssq_pkg::div_res_t               div_res;

  logic                            in_accept;
  logic                            in_bad;
  logic                            rem_zero;
  logic [VB-1:0]                   op_x, op_y;
  logic [2*VB-1:0]                 prod;

  ssq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_bad    = s_axis_tdata[ssq_pkg::IN_W-1]
                  || (s_axis_tdata == '0)
                  || ({32'd0, s_axis_tdata} > ssq_pkg::VALUE_LIMIT);
  assign rem_zero  = (div_res.remainder == '0);

  assign op_x = (state_q == ST_EVAL && rem_zero) ? VB'(b_q) : a_q;
  assign op_y = (state_q == ST_FIN) ? m_q : VB'(d_q);
  assign prod = (2*VB)'(op_x) * (2*VB)'(op_y);

  assign div_req.start    = (state_q == ST_START);
  assign div_req.dividend = m_q;
  assign div_req.divisor  = d_q;

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    d_d     = d_q;
    dsq_d   = dsq_q;
    a_d     = a_q;
    b_d     = b_q;
    par_d   = par_q;
    err_d   = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_bad) begin
            a_d     = '0;
            b_d     = '0;
            err_d   = ssq_pkg::STATUS_ERR;
            state_d = ST_DONE;
          end else begin
            m_d     = VB'(s_axis_tdata);
            d_d     = ssq_pkg::D_BITS'(2);
            dsq_d   = ssq_pkg::DSQ_BITS'(4);
            a_d     = VB'(1);
            b_d     = ssq_pkg::D_BITS'(1);
            par_d   = 1'b0;
            err_d   = ssq_pkg::STATUS_OK;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (ssq_pkg::CMP_BITS'(dsq_q) <= ssq_pkg::CMP_BITS'(m_q)) begin
          state_d = ST_START;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_res.done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (rem_zero) begin
          m_d = div_res.quotient;
          if (par_q) begin
            b_d   = ssq_pkg::D_BITS'(prod);
            par_d = 1'b0;
          end else begin
            par_d = 1'b1;
          end
          state_d = ST_START;
        end else begin
          if (par_q) begin
            a_d   = prod[VB-1:0];
            par_d = 1'b0;
          end
          d_d     = d_q + 1'b1;
          dsq_d   = dsq_q + ssq_pkg::DSQ_BITS'({d_q, 1'b1});
          state_d = ST_CHECK;
        end
      end
      ST_FIN: begin
        if (m_q > VB'(1)) begin
          a_d = prod[VB-1:0];
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    d_q   <= d_d;
    dsq_q <= dsq_d;
    a_q   <= a_d;
    b_q   <= b_d;
    par_q <= par_d;
    err_q <= err_d;
    if (out_load) begin
      out_sqf_q    <= ssq_pkg::SQF_W'(a_q);
      out_root_q   <= ssq_pkg::ROOT_W'(b_q);
      out_status_q <= err_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_status_q, out_root_q, out_sqf_q};

endmodule

// ----- hdl/ssq_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the split block, bound to the top level.
// Depends on ssq_pkg for field widths.
module ssq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [ssq_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ssq_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int ST_BIT = ssq_pkg::OUT_W - 1;
  localparam int RT_LO  = ssq_pkg::SQF_W;

  logic                           status_bit;
  logic [ssq_pkg::SQF_W-1:0]      sqf;
  logic [ssq_pkg::ROOT_W-1:0]     root;

  assign status_bit = m_axis_tdata[ST_BIT];
  assign sqf        = m_axis_tdata[ssq_pkg::SQF_W-1:0];
  assign root       = m_axis_tdata[RT_LO +: ssq_pkg::ROOT_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before the previous transaction finished");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status_bit |-> (sqf == '0) && (root == '0))
    else $error("error result carries nonzero parts");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !status_bit |-> (sqf != '0) && (root != '0))
    else $error("good result carries a zero part");

endmodule

bind squarefree_square_split_top ssq_checker u_ssq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for squarefree_square_split_top: streams numbers in,
// predicts each a * b * b split by trial division and checks every result.
// Depends on ssq_pkg and the block's RTL.
module tb;

  typedef struct packed {
    logic [ssq_pkg::STATUS_W-1:0] status;
    logic [ssq_pkg::ROOT_W-1:0]   root;
    logic [ssq_pkg::SQF_W-1:0]    sqf;
  } split_result_t;

  localparam int unsigned WATCHDOG_LIMIT = 8_000_000;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [ssq_pkg::IN_W-1:0]  s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b1;
  logic [ssq_pkg::OUT_W-1:0] m_axis_tdata;

  bit                idling_on      = 1'b1;
  split_result_t     pending_splits[$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles   = 0;

  always #5 clk_i = ~clk_i;

  squarefree_square_split_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic split_result_t split_predict(input logic [ssq_pkg::IN_W-1:0] n);
    split_result_t    r;
    longint unsigned  rem;
    longint unsigned  sqf;
    longint unsigned  root;
    longint unsigned  d;
    int unsigned      count;
    r.status = ssq_pkg::STATUS_ERR;
    r.root   = '0;
    r.sqf    = '0;
    if (n[ssq_pkg::IN_W-1] || n == '0 || 64'(n) > ssq_pkg::VALUE_LIMIT) return r;
    rem  = 64'(n);
    sqf  = 1;
    root = 1;
    d    = 2;
    while (d * d <= rem) begin
      if (rem % d == 0) begin
        count = 0;
        while (rem % d == 0) begin
          rem = rem / d;
          count++;
        end
        if (count[0]) sqf = sqf * d;
        repeat (count / 2) root = root * d;
      end
      d++;
    end
    if (rem > 1) sqf = sqf * rem;
    r.status = ssq_pkg::STATUS_OK;
    r.root   = root[ssq_pkg::ROOT_W-1:0];
    r.sqf    = sqf[ssq_pkg::SQF_W-1:0];
    return r;
  endfunction

  function automatic logic [ssq_pkg::IN_W-1:0] pick_value();
    longint unsigned m;
    longint unsigned ceiling;
    int unsigned     f;
    case ($urandom_range(0, 9))
      0: begin
        if ($urandom_range(0, 4) == 0) return '0;
        return {1'b1, 31'($urandom)};
      end
      1, 2: return ssq_pkg::IN_W'($urandom_range(1, 4095));
      3: return ssq_pkg::IN_W'($urandom_range(1, 65535));
      default: begin
        // build from small factors so that large values stay quick to split
        ceiling = 64'd1 << $urandom_range(1, 31);
        m = 1;
        repeat (40) begin
          f = $urandom_range(2, 63);
          if (m * f < ceiling) m = m * f;
        end
        f = $urandom_range(1, 4095);
        if (m * f <= ssq_pkg::VALUE_LIMIT) m = m * f;
        return m[ssq_pkg::IN_W-1:0];
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_value(input logic [ssq_pkg::IN_W-1:0] n);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= n;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_monitor
    split_result_t got;
    split_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        pending_splits = {pending_splits, split_predict(s_axis_tdata)};
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_splits.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction 0x%0h", m_axis_tdata));
        end else begin
          want = pending_splits.pop_front();
          if (got.sqf !== want.sqf)
            report_mismatch($sformatf("squarefree_part: expected %0d, got %0d",
                                      want.sqf, got.sqf));
          if (got.root !== want.root)
            report_mismatch($sformatf("square_root_part: expected %0d, got %0d",
                                      want.root, got.root));
          if (got.status !== want.status)
            report_mismatch($sformatf("status: expected %0d, got %0d",
                                      want.status, got.status));
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : result_backpressure
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_invalid_inputs();
    logic [ssq_pkg::IN_W-1:0] values[4] = '{'0, '1, 32'h8000_0000, -12345};
    foreach (values[i]) send_value(values[i]);
  endtask

  task automatic test_factor_patterns();
    logic [ssq_pkg::IN_W-1:0] values[10] = '{1, 2, 3, 4, 12, 72, 360, 97, 1024, 1000};
    foreach (values[i]) send_value(values[i]);
  endtask

  task automatic test_field_extremes();
    logic [ssq_pkg::IN_W-1:0] values[5] = '{32'd1073741824, 32'd2147395600,
                                            32'd1162261467, 32'd2147483646,
                                            32'd2147483647};
    foreach (values[i]) send_value(values[i]);
  endtask

  task automatic test_random_values();
    repeat (70) send_value(pick_value());
  endtask

  task automatic test_without_idling();
    idling_on = 1'b0;
    repeat (15) send_value(pick_value());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_invalid_inputs();
    test_factor_patterns();
    test_field_extremes();
    test_random_values();
    test_without_idling();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_splits.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
